>>> src/lowest_common_ancestor_lifting_defines.svh
// assertion macros for the lowest common ancestor engine
// included by the rtl files that carry concurrent assertions
// no dependencies
`ifndef LOWEST_COMMON_ANCESTOR_LIFTING_DEFINES_SVH
`define LOWEST_COMMON_ANCESTOR_LIFTING_DEFINES_SVH

`ifndef SYNTH

`define LCAL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

`define LCAL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define LCAL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LCAL_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> src/lcal_pkg.sv
// shared constants and request codes for the lowest common ancestor engine
// no dependencies
package lcal_pkg;

	localparam int NODE_W      = 16;
	localparam int MAX_NODES   = 65536;
	localparam int JUMP_LEVELS = 16;
	localparam int LVL_W       = $clog2(JUMP_LEVELS);
	localparam int JADDR_W     = $clog2(MAX_NODES) + LVL_W;
	localparam int DADDR_W     = $clog2(MAX_NODES);

	localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(JUMP_LEVELS - 1);

	typedef enum logic [1:0] {
		FUNC_LOAD  = 2'd0,
		FUNC_BUILD = 2'd1,
		FUNC_QUERY = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	localparam logic [2:0] ADDR_NODE_COUNT = 3'd0;

endpackage

>>> src/lowest_common_ancestor_lifting.sv
// lowest common ancestor engine using binary lifting over two on-chip memories
// depends on lcal_pkg and lowest_common_ancestor_lifting_defines.svh
//
// channel  dir  signals                          contents
// s_       in   s_tvalid s_tready s_tdata s_tuser  request: func, node_a, node_b, node_depth
// m_       out  m_tvalid m_tready m_tdata          result: ancestor (query only)
// apb      in   psel penable pwrite paddr pwdata   register node_count at address 0
//
// load: written as it is taken. build: two jump memory reads and a write per node and level
// query: depths through the single depth port, deeper node lifted by the set bits of the
// depth difference, then, unless it meets the other, both descend; one jump read per step
// memories need no clearing after reset; node 0 always reads as parent 0, depth 0
// a finished result waits in the output register while the next request is taken
`include "lowest_common_ancestor_lifting_defines.svh"

module lowest_common_ancestor_lifting
	import lcal_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // node_a, node_b, node_depth
	input  logic [1:0]  s_tuser,   // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // ancestor
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BLD_RD1,
		ST_BLD_RD2,
		ST_BLD_WR,
		ST_Q_DA,
		ST_Q_DB,
		ST_Q_DIFF,
		ST_LIFT_RD,
		ST_LIFT_WB,
		ST_CMP,
		ST_DESC_RD,
		ST_DESC_WB,
		ST_FIN_RD,
		ST_FIN_WB,
		ST_OUT
	} state_t;

	state_t state_q;

	logic [NODE_W-1:0] node_count_q;
	logic [NODE_W-1:0] u_q, v_q, p_q, a_q, b_q, du_q, diff_q, res_q;
	logic [LVL_W-1:0]  lvl_q;
	logic              m_tvalid_q;
	logic [NODE_W-1:0] m_tdata_q;

	logic [NODE_W-1:0] jump_mem [MAX_NODES*JUMP_LEVELS];
	logic [NODE_W-1:0] depth_mem [MAX_NODES];
	logic [NODE_W-1:0] jrd_a_q, jrd_b_q, drd_q;

	logic [JADDR_W-1:0] jraddr_a, jraddr_b, jwaddr;
	logic [NODE_W-1:0]  jwdata;
	logic               jwe;
	logic [DADDR_W-1:0] draddr;
	logic               dwe;

	logic [NODE_W-1:0] in_a, in_b, in_d;
	func_t             in_func;
	logic              s_acc;
	logic [NODE_W-1:0] hop_u, hop_v, db;

	assign in_a    = s_tdata[15:0];
	assign in_b    = s_tdata[31:16];
	assign in_d    = s_tdata[47:32];
	assign in_func = func_t'(s_tuser);

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_NODE_COUNT) ? {16'd0, node_count_q} : 32'd0;

	// node 0 is its own ancestor at every level
	assign hop_u = (u_q == '0) ? '0 : jrd_a_q;
	assign hop_v = (v_q == '0) ? '0 : jrd_b_q;
	assign db    = (b_q == '0) ? '0 : drd_q;

	always_comb begin
		jraddr_a = {u_q, lvl_q};
		jraddr_b = {v_q, lvl_q};
		draddr   = a_q;
		unique case (state_q)
			ST_BLD_RD1: jraddr_a = {u_q, lvl_q - LVL_W'(1)};
			ST_BLD_RD2: jraddr_a = {jrd_a_q, lvl_q - LVL_W'(1)};
			ST_FIN_RD:  jraddr_a = {u_q, LVL_W'(0)};
			ST_Q_DB:    draddr   = b_q;
			default:    draddr   = a_q;
		endcase
	end

	always_comb begin
		jwe    = 1'b0;
		jwaddr = {in_a, LVL_W'(0)};
		jwdata = in_b;
		dwe    = 1'b0;
		if (state_q == ST_BLD_WR) begin
			jwe    = 1'b1;
			jwaddr = {u_q, lvl_q};
			jwdata = (p_q == '0) ? '0 : jrd_a_q;
		end else if (s_acc && in_func == FUNC_LOAD && in_a != '0) begin
			jwe = 1'b1;
			dwe = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (jwe) begin
			jump_mem[jwaddr] <= jwdata;
		end
		jrd_a_q <= jump_mem[jraddr_a];
		jrd_b_q <= jump_mem[jraddr_b];
	end

	always_ff @(posedge clk) begin
		if (dwe) begin
			depth_mem[in_a] <= in_d;
		end
		drd_q <= depth_mem[draddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= 16'd1;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_NODE_COUNT) begin
			node_count_q <= pwdata[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			u_q        <= '0;
			v_q        <= '0;
			p_q        <= '0;
			a_q        <= '0;
			b_q        <= '0;
			du_q       <= '0;
			diff_q     <= '0;
			res_q      <= '0;
			lvl_q      <= '0;
		end else begin
			if (m_tready && state_q != ST_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						a_q <= in_a;
						b_q <= in_b;
						unique case (in_func)
							FUNC_BUILD: begin
								u_q   <= 16'd1;
								lvl_q <= LVL_W'(1);
								if (node_count_q != '0 && JUMP_LEVELS > 1) begin
									state_q <= ST_BLD_RD1;
								end
							end
							FUNC_QUERY: state_q <= ST_Q_DA;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_BLD_RD1: state_q <= ST_BLD_RD2;
				ST_BLD_RD2: begin
					p_q     <= jrd_a_q;
					state_q <= ST_BLD_WR;
				end
				ST_BLD_WR: begin
					state_q <= ST_BLD_RD1;
					if (u_q == node_count_q) begin
						u_q <= 16'd1;
						if (lvl_q == LAST_LVL) begin
							state_q <= ST_IDLE;
						end else begin
							lvl_q <= lvl_q + LVL_W'(1);
						end
					end else begin
						u_q <= u_q + 16'd1;
					end
				end
				ST_Q_DA: state_q <= ST_Q_DB;
				ST_Q_DB: begin
					du_q    <= (a_q == '0) ? '0 : drd_q;
					state_q <= ST_Q_DIFF;
				end
				ST_Q_DIFF: begin
					lvl_q   <= '0;
					state_q <= ST_LIFT_RD;
					if (du_q < db) begin
						u_q    <= b_q;
						v_q    <= a_q;
						diff_q <= db - du_q;
					end else begin
						u_q    <= a_q;
						v_q    <= b_q;
						diff_q <= du_q - db;
					end
				end
				ST_LIFT_RD: begin
					if (diff_q[lvl_q]) begin
						state_q <= ST_LIFT_WB;
					end else if (lvl_q == LAST_LVL) begin
						state_q <= ST_CMP;
					end else begin
						lvl_q <= lvl_q + LVL_W'(1);
					end
				end
				ST_LIFT_WB: begin
					u_q <= hop_u;
					if (lvl_q == LAST_LVL) begin
						state_q <= ST_CMP;
					end else begin
						lvl_q   <= lvl_q + LVL_W'(1);
						state_q <= ST_LIFT_RD;
					end
				end
				ST_CMP: begin
					lvl_q <= LAST_LVL;
					if (u_q == v_q) begin
						res_q   <= u_q;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_DESC_RD;
					end
				end
				ST_DESC_RD: state_q <= ST_DESC_WB;
				ST_DESC_WB: begin
					if (hop_u != hop_v) begin
						u_q <= hop_u;
						v_q <= hop_v;
					end
					if (lvl_q == '0) begin
						state_q <= ST_FIN_RD;
					end else begin
						lvl_q   <= lvl_q - LVL_W'(1);
						state_q <= ST_DESC_RD;
					end
				end
				ST_FIN_RD: state_q <= ST_FIN_WB;
				ST_FIN_WB: begin
					res_q   <= hop_u;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= res_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`LCAL_ASSERT_NXT(a_query_start, clk, arst_n, s_acc && s_tuser == FUNC_QUERY, state_q == ST_Q_DA)
	`LCAL_ASSERT_IMP(a_build_keeps_parents, clk, arst_n, state_q == ST_BLD_WR, lvl_q != '0)
	`LCAL_ASSERT_IMP(a_sentinel_untouched, clk, arst_n, jwe, jwaddr[JADDR_W-1:LVL_W] != '0)
	`LCAL_ASSERT_NXT(a_descent_ends, clk, arst_n, state_q == ST_DESC_WB && lvl_q == '0, state_q == ST_FIN_RD)

endmodule

>>> verif/tb.sv
// testbench for the binary lifting lowest common ancestor engine
// random trees are loaded, built and queried; a scoreboard predicts each ancestor
// depends on lcal_pkg and lowest_common_ancestor_lifting
import lcal_pkg::*;

class lca_scoreboard;
	bit [15:0] lift [MAX_NODES][JUMP_LEVELS];
	bit [15:0] depth_of [MAX_NODES];
	bit [15:0] node_count = 16'd1;
	bit [15:0] pending [$];
	int errors = 0;

	function void build_levels();
		for (int k = 1; k < JUMP_LEVELS; k++)
			for (int u = 1; u <= node_count; u++)
				lift[u][k] = lift[lift[u][k-1]][k-1];
	endfunction

	function bit [15:0] common_ancestor(bit [15:0] a, bit [15:0] b);
		bit [15:0] u, v, t, pu, pv, diff;
		u = a;
		v = b;
		if (depth_of[u] < depth_of[v]) begin
			t = u;
			u = v;
			v = t;
		end
		diff = depth_of[u] - depth_of[v];
		for (int i = 0; i < JUMP_LEVELS; i++)
			if (diff[i])
				u = lift[u][i];
		if (u == v)
			return u;
		for (int i = JUMP_LEVELS - 1; i >= 0; i--) begin
			pu = lift[u][i];
			pv = lift[v][i];
			if (pu != pv) begin
				u = pu;
				v = pv;
			end
		end
		return lift[u][0];
	endfunction

	function void note_request(func_t f, bit [15:0] a, bit [15:0] b, bit [15:0] d);
		case (f)
			FUNC_LOAD: begin
				if (a != 0) begin
					lift[a][0] = b;
					depth_of[a] = d;
				end
			end
			FUNC_BUILD: build_levels();
			FUNC_QUERY: pending = {pending, common_ancestor(a, b)};
			default: ;
		endcase
	endfunction

	function void check_result(bit [15:0] got);
		bit [15:0] want;
		if (pending.size() == 0) begin
			$error("ancestor: no query waiting, actual %0d", got);
			errors++;
		end else begin
			want = pending.pop_front();
			if (want != got) begin
				$error("ancestor: expected %0d, actual %0d", want, got);
				errors++;
			end
		end
	endfunction
endclass

module tb;
	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;   // node_a, node_b, node_depth
	logic [1:0]  s_tuser = '0;   // func
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // ancestor
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	lca_scoreboard sb = new();
	bit steady = 1'b0;
	int sent = 0;
	int loaded_upto = 0;
	int built_upto = 0;

	lowest_common_ancestor_lifting uut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	always @(posedge clk)
		m_tready <= steady || ($urandom_range(0, 99) >= 7);

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);

	task automatic send_req(input func_t f, input bit [15:0] a, b, d);
		if (!steady) begin
			while ($urandom_range(0, 99) < 7) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser  <= f;
		s_tdata  <= {d, b, a};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_request(f, a, b, d);
		if (f != FUNC_NONE && !(f == FUNC_LOAD && a == 0))
			sent++;
	endtask

	task automatic write_node_count(input bit [15:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_NODE_COUNT;
		pwdata  <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		sb.node_count = value;
	endtask

	// wait for every ancestor, then let a build in flight finish
	task automatic drain(input int settle);
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	function automatic bit [15:0] pick_node();
		if (built_upto == 0 || $urandom_range(0, 9) == 0)
			return 16'd0;
		return 16'($urandom_range(1, built_upto));
	endfunction

	task automatic run_phase(input int p);
		int n, cnt, nq, u, par, dep, last_build;
		bit [15:0] cfg, qa, qb;
		n = (p == 5) ? 150 : $urandom_range(2, 48);
		case (p)
			1: cfg = 16'd0;
			2: cfg = 16'hFFFF;
			3: cfg = 16'(n);
			4: cfg = 16'd1;
			default: cfg = ($urandom_range(0, 2) != 0) ? 16'(n) : 16'($urandom_range(1, n));
		endcase
		steady = (p == 3 || p == 4);
		write_node_count(cfg);
		// fresh forest, parents always numbered below their children
		for (u = 1; u <= n; u++) begin
			if (u == 1 || $urandom_range(0, 19) == 0)
				par = 0;
			else if ($urandom_range(0, 2) == 0)
				par = u - 1;
			else
				par = $urandom_range(1, u - 1);
			dep = (par == 0) ? 0 : int'(sb.depth_of[par]) + 1;
			if ($urandom_range(0, 14) == 0)
				dep = $urandom_range(0, 16'hFFFF);
			send_req(FUNC_LOAD, 16'(u), 16'(par), 16'(dep));
			if ($urandom_range(0, 24) == 0)
				send_req(FUNC_NONE, 16'($urandom), 16'($urandom), 16'($urandom));
			if ($urandom_range(0, 29) == 0)
				send_req(FUNC_LOAD, 16'd0, 16'($urandom), 16'($urandom));
		end
		if (n > loaded_upto)
			loaded_upto = n;
		last_build = 0;
		if (cfg <= loaded_upto) begin
			send_req(FUNC_BUILD, 16'($urandom), 16'($urandom), 16'($urandom));
			last_build = int'(cfg);
			if (cfg > built_upto)
				built_upto = int'(cfg);
		end
		nq = $urandom_range(10, 30);
		for (cnt = 0; cnt < nq; cnt++) begin
			qa = pick_node();
			qb = pick_node();
			if ($urandom_range(0, 9) == 0) begin
				qa = 16'($urandom_range(1, loaded_upto));
				qb = qa;
			end
			send_req(FUNC_QUERY, qa, qb, 16'($urandom));
			// reload without rebuild leaves stale upper levels
			if ($urandom_range(0, 14) == 0) begin
				u = $urandom_range(1, loaded_upto);
				send_req(FUNC_LOAD, 16'(u), 16'($urandom_range(0, u - 1)), 16'($urandom));
			end
		end
		drain(3 * (JUMP_LEVELS - 1) * last_build + 64);
	endtask

	initial begin
		static int tree_par [7] = '{0, 1, 1, 2, 2, 4, 3};
		static int tree_dep [7] = '{0, 1, 1, 2, 2, 3, 2};
		int p;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_node_count(16'd7);
		send_req(FUNC_LOAD, 16'd0, 16'd5, 16'd9);
		for (int i = 0; i < 7; i++)
			send_req(FUNC_LOAD, 16'(i + 1), 16'(tree_par[i]), 16'(tree_dep[i]));
		send_req(FUNC_LOAD, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_req(FUNC_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_req(FUNC_BUILD, 16'd0, 16'd0, 16'd0);
		send_req(FUNC_QUERY, 16'd4, 16'd5, 16'd0);
		send_req(FUNC_QUERY, 16'd6, 16'd7, 16'd0);
		send_req(FUNC_QUERY, 16'd6, 16'd5, 16'd0);
		send_req(FUNC_QUERY, 16'd5, 16'd6, 16'hFFFF);
		send_req(FUNC_QUERY, 16'd6, 16'd6, 16'd0);
		send_req(FUNC_QUERY, 16'd0, 16'd6, 16'd0);
		send_req(FUNC_QUERY, 16'd6, 16'd0, 16'd0);
		send_req(FUNC_QUERY, 16'd0, 16'd0, 16'd0);
		send_req(FUNC_QUERY, 16'hFFFF, 16'hFFFF, 16'd0);
		send_req(FUNC_QUERY, 16'd7, 16'd1, 16'd0);
		send_req(FUNC_QUERY, 16'd3, 16'd0, 16'd0);
		// depth far off the tree, lifting runs through the high levels
		send_req(FUNC_LOAD, 16'd7, 16'd3, 16'd40000);
		send_req(FUNC_QUERY, 16'd7, 16'd6, 16'd0);
		loaded_upto = 7;
		built_upto = 7;
		drain(3 * (JUMP_LEVELS - 1) * 7 + 64);

		p = 1;
		while (sent < 500) begin
			run_phase(p);
			p++;
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

>>> filelist.f
+incdir+src
src/lcal_pkg.sv
src/lowest_common_ancestor_lifting.sv
verif/tb.sv
